FILE: rtl/core/ptc_pkg.sv
package ptc_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CalW    = 48;

  typedef enum logic [CfgIdxW-1:0] {
    RegCalTemp  = 2'd0,
    RegCalPLow  = 2'd1,
    RegCalPMid  = 2'd2,
    RegCalPHigh = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } cal_t;

  function automatic logic [31:0] sx16(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned s);
    return 32'($signed(x) >>> s);
  endfunction

endpackage

FILE: rtl/core/ptc_div.sv
// Restoring divider, one quotient bit per stage, 32 stages.
module ptc_div import ptc_pkg::*; #(
  parameter int unsigned SideW = 53
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [31:0]      num_i,
  input  logic [31:0]      den_i,
  input  logic             dbl_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [31:0]      quo_o,
  output logic             dbl_o,
  output logic [SideW-1:0] side_o
);

  localparam int unsigned N = 32;

  // stage inputs; entry 0 is the divider input
  logic             vld_s  [N];
  logic [31:0]      num_s  [N];
  logic [31:0]      quo_s  [N];
  logic [31:0]      rem_s  [N];
  logic [31:0]      den_s  [N];
  logic             dbl_s  [N];
  logic [SideW-1:0] side_s [N];

  logic [N:1]       vld_q;
  logic [31:0]      num_q  [1:N];
  logic [31:0]      quo_q  [1:N];
  logic [31:0]      rem_q  [1:N];
  logic [31:0]      den_q  [1:N];
  logic             dbl_q  [1:N];
  logic [SideW-1:0] side_q [1:N];

  always_comb begin
    vld_s[0]  = valid_i;
    num_s[0]  = num_i;
    quo_s[0]  = '0;
    rem_s[0]  = '0;
    den_s[0]  = den_i;
    dbl_s[0]  = dbl_i;
    side_s[0] = side_i;
    for (int k = 1; k < N; k++) begin
      vld_s[k]  = vld_q[k];
      num_s[k]  = num_q[k];
      quo_s[k]  = quo_q[k];
      rem_s[k]  = rem_q[k];
      den_s[k]  = den_q[k];
      dbl_s[k]  = dbl_q[k];
      side_s[k] = side_q[k];
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [32:0] sh;
    logic [32:0] df;
    logic        ge;
    always_comb begin
      sh = {rem_s[g], num_s[g][31]};
      df = sh - {1'b0, den_s[g]};
      ge = ~df[32];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= vld_s[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[g+1]  <= {num_s[g][30:0], 1'b0};
        quo_q[g+1]  <= {quo_s[g][30:0], ge};
        rem_q[g+1]  <= ge ? df[31:0] : sh[31:0];
        den_q[g+1]  <= den_s[g];
        dbl_q[g+1]  <= dbl_s[g];
        side_q[g+1] <= side_s[g];
      end
    end
  end

  assign valid_o = vld_q[N];
  assign quo_o   = quo_q[N];
  assign dbl_o   = dbl_q[N];
  assign side_o  = side_q[N];

endmodule

FILE: rtl/core/pressure_temperature_compensation.sv
// Pipeline: 11 arithmetic stages, a 32-stage bit-per-stage divider, 3 back-end stages
// and one output register.
// Throughput: one item per cycle; all stages hold while a result waits on tready.
// Reset: asynchronous active low; clears valid bits and calibration registers to 0.
module pressure_temperature_compensation import ptc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [39:0]       s_axis_tdata,  // raw_temperature[19:0], raw_pressure[39:20]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [55:0]       m_axis_tdata,  // temperature_mdeg[20:0], pressure_pa[52:21]
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CalW-1:0]   cfg_data_i
);

  localparam int unsigned NS = 11;

  logic [CalW-1:0] cal_t_q, cal_pl_q, cal_pm_q, cal_ph_q;
  cal_t c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_t_q  <= '0;
      cal_pl_q <= '0;
      cal_pm_q <= '0;
      cal_ph_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegCalTemp:  cal_t_q  <= cfg_data_i;
        RegCalPLow:  cal_pl_q <= cfg_data_i;
        RegCalPMid:  cal_pm_q <= cfg_data_i;
        RegCalPHigh: cal_ph_q <= cfg_data_i;
        default: ;
      endcase
    end
  end
  assign cfg_ready_o = 1'b1;

  always_comb begin
    c.t1 = cal_t_q[15:0];  c.t2 = cal_t_q[31:16];  c.t3 = cal_t_q[47:32];
    c.p1 = cal_pl_q[15:0]; c.p2 = cal_pl_q[31:16]; c.p3 = cal_pl_q[47:32];
    c.p4 = cal_pm_q[15:0]; c.p5 = cal_pm_q[31:16]; c.p6 = cal_pm_q[47:32];
    c.p7 = cal_ph_q[15:0]; c.p8 = cal_ph_q[31:16]; c.p9 = cal_ph_q[47:32];
  end

  logic en;
  logic out_v_q;
  assign en = ~out_v_q | m_axis_tready;
  assign s_axis_tready = en;

  // Front pipeline: fixed-point arithmetic, with up to three multiplies in a stage.
  logic        v_s   [NS];
  logic [19:0] adp_s [NS];
  logic [31:0] r0_s [NS], r1_s [NS], r2_s [NS], r3_s [NS], r4_s [NS];
  logic [NS:1] v_q;
  logic [19:0] adp_q [1:NS];
  logic [31:0] r0_q [1:NS], r1_q [1:NS], r2_q [1:NS], r3_q [1:NS], r4_q [1:NS];
  logic [31:0] r0_d [NS], r1_d [NS], r2_d [NS], r3_d [NS], r4_d [NS];

  // stage inputs; entry 0 is the input transaction
  always_comb begin
    v_s[0]   = s_axis_tvalid;
    adp_s[0] = s_axis_tdata[39:20];
    r0_s[0]  = {12'd0, s_axis_tdata[19:0]};
    r1_s[0]  = '0; r2_s[0] = '0; r3_s[0] = '0; r4_s[0] = '0;
    for (int s = 1; s < NS; s++) begin
      v_s[s]   = v_q[s];
      adp_s[s] = adp_q[s];
      r0_s[s]  = r0_q[s]; r1_s[s] = r1_q[s]; r2_s[s] = r2_q[s];
      r3_s[s]  = r3_q[s]; r4_s[s] = r4_q[s];
    end
  end

  // r0: t_fine / tq path, r1..r4 scratch; each stage carries forward by default.
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      r0_d[s] = r0_s[s]; r1_d[s] = r1_s[s]; r2_d[s] = r2_s[s];
      r3_d[s] = r3_s[s]; r4_d[s] = r4_s[s];
    end
    // s0: a0, b0
    r1_d[0] = (r0_s[0] >> 3) - ({16'd0, c.t1} << 1);
    r2_d[0] = (r0_s[0] >> 4) - {16'd0, c.t1};
    // s1: a*t2, b*b
    r1_d[1] = asr(r1_s[1] * sx16(c.t2), 11);
    r2_d[1] = asr(r2_s[1] * r2_s[1], 12);
    // s2: b*t3
    r2_d[2] = asr(r2_s[2] * sx16(c.t3), 14);
    // s3: t_fine
    r0_d[3] = r1_s[3] + r2_s[3];
    // s4: tq product, pressure a, q
    r3_d[4] = 32'd800 * r0_s[4] + 32'd2048;
    r1_d[4] = asr(r0_s[4], 1) - 32'd64000;
    r2_d[4] = asr(asr(r0_s[4], 1) - 32'd64000, 2);
    // s5: q*q, a*p5, a*p2 ; tq finish
    r0_d[5] = 32'(($signed(r3_s[5]) + ($signed(r3_s[5]) < 0 ? 32'sd4095 : 32'sd0)) >>> 12);
    r4_d[5] = r2_s[5] * r2_s[5];
    r2_d[5] = (r1_s[5] * sx16(c.p5)) << 1;
    r3_d[5] = asr(sx16(c.p2) * r1_s[5], 1);
    // s6: b6 = (qq>>11)*p6 ; qq>>13 kept
    r1_d[6] = asr(r4_s[6], 11) * sx16(c.p6);
    r4_d[6] = asr(r4_s[6], 13);
    // s7: b = ((b6 + a5)>>2) + p4<<16 ; p3*x
    r1_d[7] = asr(r1_s[7] + r2_s[7], 2) + (sx16(c.p4) << 16);
    r4_d[7] = sx16(c.p3) * r4_s[7];
    // s8: a = ((p3x>>3)+p2a)>>18 + 32768
    r4_d[8] = asr(asr(r4_s[8], 3) + r3_s[8], 18) + 32'd32768;
    // s9: a*p1 ; p base
    r4_d[9] = asr(r4_s[9] * {16'd0, c.p1}, 15);
    r2_d[9] = (32'd1048576 - {12'd0, adp_s[9]}) - asr(r1_s[9], 12);
    // s10: *3125, divisor
    r2_d[10] = r2_s[10] * 32'd3125;
    r4_d[10] = (r4_s[10] == '0) ? 32'd1 : r4_s[10];
  end

  for (genvar s = 0; s < NS; s++) begin : g_fs
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[s+1] <= 1'b0;
      else if (en) v_q[s+1] <= v_s[s];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        adp_q[s+1] <= adp_s[s];
        r0_q[s+1] <= r0_d[s]; r1_q[s+1] <= r1_d[s]; r2_q[s+1] <= r2_d[s];
        r3_q[s+1] <= r3_d[s]; r4_q[s+1] <= r4_d[s];
      end
    end
  end

  // Divide stage
  logic        big;
  logic [31:0] dnum;
  assign big  = r2_q[11][31];
  assign dnum = big ? r2_q[11] : (r2_q[11] << 1);

  logic        dv_v, dv_dbl;
  logic [31:0] dv_q;
  logic [20:0] dv_t;
  ptc_div #(.SideW(21)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_q[11]), .num_i(dnum), .den_i(r4_q[11]),
    .dbl_i(big), .side_i(r0_q[11][20:0]),
    .valid_o(dv_v), .quo_o(dv_q), .dbl_o(dv_dbl), .side_o(dv_t)
  );

  // Back pipeline: 3 stages
  logic [2:0]  bv_q;
  logic [20:0] bt_q [3];
  logic [31:0] bp_q [3], ba_q [2], bb_q [2];
  logic [31:0] p8x, pq;
  assign p8x = dv_dbl ? (dv_q << 1) : dv_q;
  assign pq  = (p8x >> 3) * (p8x >> 3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bv_q <= '0;
    else if (en) bv_q <= {bv_q[1:0], dv_v};
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      bt_q[0] <= dv_t;  bp_q[0] <= p8x;
      ba_q[0] <= pq >> 13;
      bb_q[0] <= asr((p8x >> 2) * sx16(c.p8), 13);
      bt_q[1] <= bt_q[0]; bp_q[1] <= bp_q[0]; bb_q[1] <= bb_q[0];
      ba_q[1] <= asr(sx16(c.p9) * ba_q[0], 12);
      bt_q[2] <= bt_q[1];
      bp_q[2] <= bp_q[1] + asr(ba_q[1] + bb_q[1] + sx16(c.p7), 4);
    end
  end

  logic [55:0] out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= bv_q[2];
  end
  always_ff @(posedge clk_i) begin
    if (en) out_q <= {3'd0, bp_q[2], bt_q[2]};
  end
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

FILE: rtl/core/ptc_checker.sv
module ptc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);
  // Stalls propagate straight back to the input.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("no backpressure");
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("idle but not ready");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[55:53] == 3'd0) else $error("pad bits");
endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ptc_pkg::*;

  localparam int unsigned PipeLat = 47;
  localparam int unsigned NumRand = 1030;

  // lowest field last
  typedef struct packed {
    logic [19:0] raw_p;
    logic [19:0] raw_t;
  } sample_t;

  typedef struct packed {
    logic [31:0] press_pa;
    logic [20:0] temp_mdeg;
  } comp_t;

  typedef struct {
    sample_t smp;
    bit      has_exp;
    comp_t   exp;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CalW-1:0]    cfg_data_i;

  logic [47:0] cal_regs [4];
  comp_t       comp_q [$];
  int          n_fail;
  bit          idle_ok;
  bit          hold_go;
  bit          hold_rx;

  pressure_temperature_compensation u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("tb_top failed");
    $finish;
  end

  function automatic logic [31:0] sra32(logic [31:0] x, int s);
    return $signed(x) >>> s;
  endfunction

  function automatic logic [31:0] cal_word(int r, int k, bit sgn);
    logic [15:0] w;
    w = cal_regs[r][16*k +: 16];
    return sgn ? {{16{w[15]}}, w} : {16'h0, w};
  endfunction

  // 32-bit wrapping compensation, word for word as the sensor datasheet math
  function automatic comp_t compensate(sample_t s);
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] at, ap, a, b, tf, p, q, d, x;
    comp_t r;
    t1 = cal_word(RegCalTemp, 0, 0);  t2 = cal_word(RegCalTemp, 1, 1);
    t3 = cal_word(RegCalTemp, 2, 1);
    p1 = cal_word(RegCalPLow, 0, 0);  p2 = cal_word(RegCalPLow, 1, 1);
    p3 = cal_word(RegCalPLow, 2, 1);
    p4 = cal_word(RegCalPMid, 0, 1);  p5 = cal_word(RegCalPMid, 1, 1);
    p6 = cal_word(RegCalPMid, 2, 1);
    p7 = cal_word(RegCalPHigh, 0, 1); p8 = cal_word(RegCalPHigh, 1, 1);
    p9 = cal_word(RegCalPHigh, 2, 1);
    at = {12'h0, s.raw_t};
    ap = {12'h0, s.raw_p};
    a = (at >> 3) - (t1 << 1);
    a = sra32(a * t2, 11);
    b = (at >> 4) - t1;
    b = sra32(b * b, 12);
    b = sra32(b * t3, 14);
    tf = a + b;
    x = 32'd800 * tf + 32'd2048;
    r.temp_mdeg = 21'($signed(x) / 32'sd4096);
    a = sra32(tf, 1) - 32'd64000;
    q = sra32(a, 2);
    b = sra32(q * q, 11);
    b = b * p6;
    b = b + ((a * p5) << 1);
    b = sra32(b, 2);
    b = b + (p4 << 16);
    a = sra32(sra32(p3 * sra32(q * q, 13), 3) + sra32(p2 * a, 1), 18);
    a = a + 32'd32768;
    a = a * p1;
    a = sra32(a, 15);
    d = (a == 0) ? 32'd1 : a;
    p = 32'd1048576 - ap;
    p = p - sra32(b, 12);
    p = p * 32'd3125;
    if (p < 32'h8000_0000) p = (p << 1) / d;
    else p = (p / d) * 32'd2;
    a = sra32(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
    b = sra32((p >> 2) * p8, 13);
    r.press_pa = p + sra32(a + b + p7, 4);
    return r;
  endfunction

  task automatic write_cal(cfg_reg_e idx, logic [47:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cal_regs[idx] = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_sample(sample_t s, bit has_exp, comp_t exp);
    while (idle_ok && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    comp_q.push_back(has_exp ? exp : compensate(s));
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (comp_q.size() != 0) @(negedge clk_i);
    repeat (PipeLat + 10) @(negedge clk_i);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  // datasheet-like calibration, perturbed so signs and magnitudes vary
  function automatic logic [47:0] typical_cal(int r);
    logic [15:0] w [3];
    case (r)
      RegCalTemp: begin w[0] = 16'd27504; w[1] = 16'd26435; w[2] = -16'sd1000; end
      RegCalPLow: begin w[0] = 16'd36477; w[1] = -16'sd10685; w[2] = 16'd3024; end
      RegCalPMid: begin w[0] = 16'd2855;  w[1] = 16'd140;  w[2] = -16'sd7; end
      default: begin w[0] = 16'd15500; w[1] = -16'sd14600; w[2] = 16'd6000; end
    endcase
    for (int k = 0; k < 3; k++) w[k] = w[k] + 16'($signed($urandom_range(64)) - 32);
    return {w[2], w[1], w[0]};
  endfunction

  // sink: random stall plus one long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= !hold_rx && !(idle_ok && $urandom_range(99) < 8);
  end

  always @(posedge clk_i) begin
    comp_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[52:0];
      if (comp_q.size() == 0) begin
        $error("result with nothing expected: %h", got);
        n_fail++;
      end else begin
        want = comp_q.pop_front();
        if (got.temp_mdeg !== want.temp_mdeg) begin
          $error("temperature_mdeg exp %0d got %0d",
                 $signed(want.temp_mdeg), $signed(got.temp_mdeg));
          n_fail++;
        end
        if (got.press_pa !== want.press_pa) begin
          $error("pressure_pa exp %0d got %0d",
                 $signed(want.press_pa), $signed(got.press_pa));
          n_fail++;
        end
      end
    end
  end

  initial begin
    int hold_cnt;
    hold_cnt = 0;
    hold_rx = 1'b0;
    wait (hold_go);
    hold_rx = 1'b1;
    while (hold_cnt < 200) begin
      @(posedge clk_i);
      hold_cnt++;
    end
    hold_rx = 1'b0;
  end

  initial begin
    dir_row_t dir_tbl [$];
    dir_row_t row;
    comp_t    nil;
    sample_t  s;
    int       timeout;
    n_fail = 0;
    idle_ok = 1'b0;
    hold_go = 1'b0;
    nil = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = RegCalTemp;
    cfg_data_i    = '0;
    for (int r = 0; r < 4; r++) cal_regs[r] = '0;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // all-zero calibration: t_fine 0, divisor forced to 1, big-p path
    row.has_exp = 1; row.smp = '0;
    row.exp = '{32'd2258632704, 21'd0};
    dir_tbl.push_back(row);
    row.has_exp = 0;
    row.smp = '{20'hFFFFF, 20'hFFFFF}; dir_tbl.push_back(row);
    row.smp = '{20'h0, 20'hFFFFF};     dir_tbl.push_back(row);
    row.smp = '{20'hFFFFF, 20'h0};     dir_tbl.push_back(row);
    foreach (dir_tbl[i])
      send_sample(dir_tbl[i].smp, dir_tbl[i].has_exp, dir_tbl[i].exp);
    drain();

    // extremes of each calibration register, then realistic values
    for (int phase = 0; phase < 4; phase++) begin
      for (int r = 0; r < 4; r++) begin
        case (phase)
          0: write_cal(cfg_reg_e'(r), 48'hFFFF_FFFF_FFFF);
          1: write_cal(cfg_reg_e'(r), 48'h7FFF_8000_FFFF);
          2: write_cal(cfg_reg_e'(r), 48'h8000_7FFF_0001);
          default: write_cal(cfg_reg_e'(r), typical_cal(r));
        endcase
      end
      for (int i = 0; i < 5; i++) begin
        s = '{20'((4 - i) * 262143), 20'(i * 262143)};
        send_sample(s, 0, nil);
      end
      drain();
    end

    idle_ok = 1'b1;
    for (int i = 0; i < NumRand; i++) begin
      if (i % 130 == 0 && i != 0) begin
        drain();
        for (int r = 0; r < 4; r++)
          write_cal(cfg_reg_e'(r), ($urandom_range(3) == 0) ? rand48() : typical_cal(r));
      end
      if (i == 300) hold_go = 1'b1;
      idle_ok = !(i >= 600 && i < 750);
      if ($urandom_range(3) == 0) s = {20'($urandom()), 20'($urandom())};
      else s = '{20'($urandom_range(500000, 250000)), 20'($urandom_range(600000, 400000))};
      send_sample(s, 0, nil);
    end
    s_axis_tvalid <= 1'b0;
    timeout = 0;
    while (comp_q.size() != 0 && timeout < 100000) begin
      @(negedge clk_i);
      timeout++;
    end
    if (comp_q.size() != 0) begin
      $display("tb_top failed");
      $finish;
    end
    repeat (PipeLat + 10) @(negedge clk_i);
    if (n_fail == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/ptc_pkg.sv
rtl/core/ptc_div.sv
rtl/core/pressure_temperature_compensation.sv
rtl/core/ptc_checker.sv
tb/tb_top.sv
